// File: hdl/fpp_pkg.sv
// ----------------------------------------------------------------------------
// fpp_pkg: shared types and constants of the position parser
// board slot codes, memory port bundles, scalar snapshot and piece decode
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int NumBoards   = 12;
  localparam int SlotW       = 4;
  localparam int BoardW      = 64;
  localparam int SquareW     = 6;
  localparam int CountW      = 16;
  localparam int OutTdataW   = 112;
  localparam int OutTuserW   = 4;

  // board slot codes
  localparam logic [SlotW-1:0] SLOT_W_PAWN   = 4'd0;
  localparam logic [SlotW-1:0] SLOT_W_ROOK   = 4'd1;
  localparam logic [SlotW-1:0] SLOT_W_KNIGHT = 4'd2;
  localparam logic [SlotW-1:0] SLOT_W_BISHOP = 4'd3;
  localparam logic [SlotW-1:0] SLOT_W_QUEEN  = 4'd4;
  localparam logic [SlotW-1:0] SLOT_W_KING   = 4'd5;
  localparam logic [SlotW-1:0] SLOT_B_PAWN   = 4'd6;
  localparam logic [SlotW-1:0] SLOT_B_ROOK   = 4'd7;
  localparam logic [SlotW-1:0] SLOT_B_KNIGHT = 4'd8;
  localparam logic [SlotW-1:0] SLOT_B_BISHOP = 4'd9;
  localparam logic [SlotW-1:0] SLOT_B_QUEEN  = 4'd10;
  localparam logic [SlotW-1:0] SLOT_B_KING   = 4'd11;
  localparam logic [SlotW-1:0] SLOT_WHITE    = 4'd12;
  localparam logic [SlotW-1:0] SLOT_BLACK    = 4'd13;
  localparam logic [SlotW-1:0] SLOT_ALL      = 4'd14;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  addr;
    logic [BoardW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic               side_white;
    logic [3:0]         castle;     // bit0 wk, bit1 wq, bit2 bk, bit3 bq
    logic               ep_valid;
    logic [SquareW-1:0] ep_square;
    logic [CountW-1:0]  half;
    logic [CountW-1:0]  full;
  } snap_t;

  // piece letter to board slot, hit flag in the top bit
  function automatic logic [SlotW:0] slot_of(input logic [7:0] c);
    logic [SlotW:0] res;
    begin
      res = '0;
      case (c)
        8'h50: res = {1'b1, SLOT_W_PAWN};
        8'h52: res = {1'b1, SLOT_W_ROOK};
        8'h4E: res = {1'b1, SLOT_W_KNIGHT};
        8'h42: res = {1'b1, SLOT_W_BISHOP};
        8'h51: res = {1'b1, SLOT_W_QUEEN};
        8'h4B: res = {1'b1, SLOT_W_KING};
        8'h70: res = {1'b1, SLOT_B_PAWN};
        8'h72: res = {1'b1, SLOT_B_ROOK};
        8'h6E: res = {1'b1, SLOT_B_KNIGHT};
        8'h62: res = {1'b1, SLOT_B_BISHOP};
        8'h71: res = {1'b1, SLOT_B_QUEEN};
        8'h6B: res = {1'b1, SLOT_B_KING};
        default: res = '0;
      endcase
      return res;
    end
  endfunction

endpackage

// File: hdl/fpp_board_mem.sv
// ----------------------------------------------------------------------------
// fpp_board_mem: piece board store
// twelve 64-bit boards, one write and one registered read port, write-first
// bypass on a same-entry collision, per-entry valid bits with a bulk clear
// ----------------------------------------------------------------------------
module fpp_board_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fpp_pkg::mem_rd_t       rd,
  input  fpp_pkg::mem_wr_t       wr,
  input  logic                   clr,
  output logic [fpp_pkg::BoardW-1:0] rd_data
);
  import fpp_pkg::*;

  logic [BoardW-1:0]    mem [NumBoards];
  logic [NumBoards-1:0] valid_r;
  logic [BoardW-1:0]    rd_data_r;
  logic                 rd_valid_r;
  logic                 bypass;

  assign bypass = wr.en && (wr.addr == rd.addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= bypass ? wr.data : mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (clr) begin
        valid_r <= '0;
      end else if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid_r <= bypass || valid_r[rd.addr];
      end
    end
  end

  // an entry never written since the last clear reads as empty
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// File: hdl/fpp_parser.sv
// ----------------------------------------------------------------------------
// fpp_parser: per-byte decode of the position string
// holds the scalar fields, issues board reads and the merged write-back
// ----------------------------------------------------------------------------
module fpp_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [7:0]                 symbol,
  input  logic                       last,
  input  logic [fpp_pkg::BoardW-1:0] rd_data,
  output fpp_pkg::mem_rd_t           rd,
  output fpp_pkg::mem_wr_t           wr,
  output fpp_pkg::snap_t             snap
);
  import fpp_pkg::*;

  localparam logic [2:0] FLD_PLACE   = 3'd0;
  localparam logic [2:0] FLD_SIDE    = 3'd1;
  localparam logic [2:0] FLD_CASTLE  = 3'd2;
  localparam logic [2:0] FLD_PASSANT = 3'd3;
  localparam logic [2:0] FLD_HALF    = 3'd4;
  localparam logic [2:0] FLD_FULL    = 3'd5;
  localparam logic [2:0] FLD_MAX     = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_H_LO  = 8'h68;
  localparam logic [7:0] CH_K_UP  = 8'h4B;
  localparam logic [7:0] CH_Q_UP  = 8'h51;
  localparam logic [7:0] CH_K_LO  = 8'h6B;
  localparam logic [7:0] CH_Q_LO  = 8'h71;
  localparam logic [7:0] CH_W_LO  = 8'h77;
  localparam logic [7:0] CH_B_LO  = 8'h62;

  localparam logic [7:0] START_SQ  = 8'd56;
  localparam logic [7:0] RANK_BACK = 8'd16;

  function automatic logic [CountW-1:0] add_digit(input logic [CountW-1:0] v,
                                                  input logic [3:0] d);
    logic [CountW+3:0] t;
    begin
      t = {v, 3'b000} + {2'b00, v, 1'b0} + {{CountW{1'b0}}, d};
      return (t > {4'd0, {CountW{1'b1}}}) ? {CountW{1'b1}} : t[CountW-1:0];
    end
  endfunction

  logic [7:0]         sq_r, sq_nxt;
  logic [2:0]         field_r, field_nxt;
  logic               side_r, side_nxt;
  logic [3:0]         castle_r, castle_nxt;
  logic               ep_v_r, ep_v_nxt;
  logic [SquareW-1:0] ep_sq_r, ep_sq_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [2:0]         pend_col_r, pend_col_nxt;
  logic [CountW-1:0]  half_r, half_nxt;
  logic [CountW-1:0]  full_r, full_nxt;
  logic               b_v_r, b_v_nxt;
  logic [SlotW-1:0]   b_slot_r, b_slot_nxt;
  logic [SquareW-1:0] b_sq_r, b_sq_nxt;

  logic               digit;
  logic               consumed;
  logic [2:0]         field_v;
  logic [SlotW:0]     piece;
  logic [2:0]         rank;

  assign digit = (symbol >= CH_0) && (symbol <= CH_9);
  assign piece = slot_of(symbol);
  assign rank  = 3'(symbol[3:0] - 4'd1);

  always_comb begin
    sq_nxt       = sq_r;
    field_nxt    = field_r;
    side_nxt     = side_r;
    castle_nxt   = castle_r;
    ep_v_nxt     = ep_v_r;
    ep_sq_nxt    = ep_sq_r;
    pend_v_nxt   = pend_v_r;
    pend_col_nxt = pend_col_r;
    half_nxt     = half_r;
    full_nxt     = full_r;
    b_v_nxt      = 1'b0;
    b_slot_nxt   = b_slot_r;
    b_sq_nxt     = b_sq_r;
    consumed     = 1'b0;
    field_v      = field_r;
    rd           = '0;
    if (accept) begin
      // a digit right after the en-passant file completes the square
      if (pend_v_r) begin
        pend_v_nxt = 1'b0;
        if (digit) begin
          consumed = 1'b1;
          if ((symbol >= CH_1) && (symbol <= CH_8)) begin
            ep_v_nxt  = 1'b1;
            ep_sq_nxt = {rank, pend_col_r};
          end
        end
      end
      if (!consumed) begin
        if (field_r == FLD_PLACE) begin
          if (digit) begin
            sq_nxt = sq_r + {4'd0, symbol[3:0]};
          end else if (symbol == CH_SLASH) begin
            sq_nxt = sq_r - RANK_BACK;
          end else begin
            if (piece[SlotW] && (sq_r[7:6] == 2'b00)) begin
              rd.en      = 1'b1;
              rd.addr    = piece[SlotW-1:0];
              b_v_nxt    = 1'b1;
              b_slot_nxt = piece[SlotW-1:0];
              b_sq_nxt   = sq_r[SquareW-1:0];
            end
            sq_nxt = sq_r + 8'd1;
          end
        end
        if ((symbol == CH_SPACE) && (field_r != FLD_MAX)) begin
          field_v = field_r + 3'd1;
        end
        field_nxt = field_v;
        case (field_v)
          FLD_SIDE: begin
            if (symbol == CH_W_LO) side_nxt = 1'b1;
            if (symbol == CH_B_LO) side_nxt = 1'b0;
          end
          FLD_CASTLE: begin
            if (symbol == CH_K_UP) castle_nxt[0] = 1'b1;
            if (symbol == CH_Q_UP) castle_nxt[1] = 1'b1;
            if (symbol == CH_K_LO) castle_nxt[2] = 1'b1;
            if (symbol == CH_Q_LO) castle_nxt[3] = 1'b1;
            if (symbol == CH_DASH) castle_nxt    = '0;
          end
          FLD_PASSANT: begin
            if (symbol == CH_DASH) begin
              ep_v_nxt = 1'b0;
            end else if ((symbol >= CH_A_LO) && (symbol <= CH_H_LO)) begin
              pend_v_nxt   = 1'b1;
              pend_col_nxt = symbol[2:0] - 3'd1;
            end
          end
          FLD_HALF: begin
            if (digit) half_nxt = add_digit(half_r, symbol[3:0]);
          end
          FLD_FULL: begin
            if (digit) full_nxt = add_digit(full_r, symbol[3:0]);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // values after this byte, before the end-of-string clear
  assign snap.side_white = side_nxt;
  assign snap.castle     = castle_nxt;
  assign snap.ep_valid   = ep_v_nxt;
  assign snap.ep_square  = ep_v_nxt ? ep_sq_nxt : '0;
  assign snap.half       = half_nxt;
  assign snap.full       = full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r       <= START_SQ;
      field_r    <= FLD_PLACE;
      side_r     <= 1'b1;
      castle_r   <= '0;
      ep_v_r     <= 1'b0;
      ep_sq_r    <= '0;
      pend_v_r   <= 1'b0;
      pend_col_r <= '0;
      half_r     <= '0;
      full_r     <= '0;
      b_v_r      <= 1'b0;
    end else begin
      side_r  <= side_nxt;
      ep_v_r  <= ep_v_nxt;
      ep_sq_r <= ep_sq_nxt;
      b_v_r   <= b_v_nxt;
      if (accept && last) begin
        sq_r       <= START_SQ;
        field_r    <= FLD_PLACE;
        castle_r   <= '0;
        pend_v_r   <= 1'b0;
        pend_col_r <= '0;
        half_r     <= '0;
        full_r     <= '0;
      end else begin
        sq_r       <= sq_nxt;
        field_r    <= field_nxt;
        castle_r   <= castle_nxt;
        pend_v_r   <= pend_v_nxt;
        pend_col_r <= pend_col_nxt;
        half_r     <= half_nxt;
        full_r     <= full_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_slot_r <= b_slot_nxt;
    b_sq_r   <= b_sq_nxt;
  end

  // write-back stage: board read in the previous cycle, set the square bit
  assign wr.en   = b_v_r;
  assign wr.addr = b_slot_r;
  assign wr.data = rd_data | ({{(BoardW-1){1'b0}}, 1'b1} << b_sq_r);

endmodule

// File: hdl/fpp_emit.sv
// ----------------------------------------------------------------------------
// fpp_emit: result sequencer
// reads the twelve boards in order, builds the unions and drives the
// output register, then clears the board store
// ----------------------------------------------------------------------------
module fpp_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  fpp_pkg::snap_t             snap,
  input  logic [fpp_pkg::BoardW-1:0] rd_data,
  input  logic                       out_ready,
  output fpp_pkg::mem_rd_t           rd,
  output logic                       clr,
  output logic                       busy,
  output logic                       out_valid,
  output logic [fpp_pkg::SlotW-1:0]  out_slot,
  output logic [fpp_pkg::BoardW-1:0] out_bits,
  output fpp_pkg::snap_t             out_snap,
  output logic                       out_last
);
  import fpp_pkg::*;

  typedef enum logic {EM_IDLE, EM_RUN} em_state_t;

  localparam logic [SlotW-1:0] RdEnd = SlotW'(NumBoards);

  em_state_t         state_r, state_nxt;
  logic [SlotW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [SlotW-1:0]  slot_r, slot_nxt;
  logic              pend_r, pend_nxt;
  logic [BoardW-1:0] white_r, white_nxt;
  logic [BoardW-1:0] black_r, black_nxt;
  snap_t             snap_r, snap_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SlotW-1:0]  out_slot_r, out_slot_nxt;
  logic [BoardW-1:0] out_bits_r, out_bits_nxt;
  snap_t             out_snap_r, out_snap_nxt;
  logic              out_last_r, out_last_nxt;

  logic              running;
  logic              from_mem;
  logic              load;
  logic              issue;
  logic [BoardW-1:0] load_bits;

  assign running  = (state_r == EM_RUN);
  assign from_mem = (slot_r < SLOT_WHITE);
  assign load     = running && (!out_valid_r || out_ready) && (!from_mem || pend_r);
  assign issue    = running && (rd_idx_r != RdEnd) && (!pend_r || load);

  always_comb begin
    case (slot_r)
      SLOT_WHITE: load_bits = white_r;
      SLOT_BLACK: load_bits = black_r;
      SLOT_ALL:   load_bits = white_r | black_r;
      default:    load_bits = rd_data;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    slot_nxt      = slot_r;
    pend_nxt      = pend_r;
    white_nxt     = white_r;
    black_nxt     = black_r;
    snap_nxt      = snap_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_slot_nxt  = out_slot_r;
    out_bits_nxt  = out_bits_r;
    out_snap_nxt  = out_snap_r;
    out_last_nxt  = out_last_r;
    if (start) begin
      state_nxt  = EM_RUN;
      rd_idx_nxt = '0;
      slot_nxt   = '0;
      pend_nxt   = 1'b0;
      white_nxt  = '0;
      black_nxt  = '0;
      snap_nxt   = snap;
    end else if (running) begin
      if (load) begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = slot_r;
        out_bits_nxt  = load_bits;
        out_snap_nxt  = snap_r;
        out_last_nxt  = (slot_r == SLOT_ALL);
        slot_nxt      = slot_r + 4'd1;
        if (slot_r < SLOT_B_PAWN) begin
          white_nxt = white_r | rd_data;
        end else if (from_mem) begin
          black_nxt = black_r | rd_data;
        end
        if (from_mem) begin
          pend_nxt = 1'b0;
        end
        if (slot_r == SLOT_ALL) begin
          state_nxt = EM_IDLE;
        end
      end
      if (issue) begin
        pend_nxt   = 1'b1;
        rd_idx_nxt = rd_idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      rd_idx_r    <= '0;
      slot_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      slot_r      <= slot_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    white_r    <= white_nxt;
    black_r    <= black_nxt;
    snap_r     <= snap_nxt;
    out_slot_r <= out_slot_nxt;
    out_bits_r <= out_bits_nxt;
    out_snap_r <= out_snap_nxt;
  end

  assign rd.en     = issue;
  assign rd.addr   = rd_idx_r;
  assign clr       = load && (slot_r == SLOT_ALL);
  assign busy      = running;
  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_bits  = out_bits_r;
  assign out_snap  = out_snap_r;
  assign out_last  = out_last_r;

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> out_valid_r && out_last_r && (out_slot_r == SLOT_ALL))
    else $error("final union not marked last");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !running |-> !pend_r)
    else $error("board read pending outside a run");

  a_clr_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    clr |-> (rd_idx_r == RdEnd) && !pend_r)
    else $error("store cleared before all boards were read");

endmodule

// File: hdl/fen_position_parser.sv
// ----------------------------------------------------------------------------
// fen_position_parser: position string to occupancy boards
// byte-wise parser with the piece boards held in a small synchronous memory
// ----------------------------------------------------------------------------
// usage
//   in_*  : one ascii byte per transaction in in_tdata[7:0], in_tlast on the
//           final byte of the string
//   out_* : fifteen transactions per string, board slot in out_tuser,
//           the board and the scalar fields in out_tdata, out_tlast on the
//           fifteenth (the all-piece union)
// throughput
//   ordinary bytes are taken one per cycle; a piece letter does a
//   read-modify-write of its board in the store, a registered read and then
//   the write-back stage, overlapped with the next byte through the store's
//   write-first bypass; after the final byte in_tready stays low while the
//   fifteen results go out, at best one per cycle with a ready receiver
// first result
//   the first result follows the run start, board read and output registers
// reset and stall
//   rst_n clears the parser fields, the store valid bits and the sequencer;
//   a stalled receiver holds the output register and pauses the board reads
// ----------------------------------------------------------------------------
module fen_position_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] symbol
  input  logic                              in_tlast,  // end_of_text
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [63:0] board_bits, [64] white_to_move, [65] castle_white_king,
  // [66] castle_white_queen, [67] castle_black_king, [68] castle_black_queen,
  // [69] passant_valid, [75:70] passant_square, [91:76] halfmove_clock,
  // [107:92] fullmove_number, [111:108] zero
  output logic [fpp_pkg::OutTdataW-1:0]     out_tdata,
  output logic [fpp_pkg::OutTuserW-1:0]     out_tuser, // [3:0] board_slot
  output logic                              out_tlast  // run_last
);
  import fpp_pkg::*;

  logic              in_fire;
  logic              emit_busy;
  logic              mem_clr;
  logic [BoardW-1:0] mem_rd_data;
  mem_rd_t           p_rd;
  mem_rd_t           e_rd;
  mem_rd_t           m_rd;
  mem_wr_t           p_wr;
  snap_t             p_snap;
  snap_t             o_snap;
  logic [SlotW-1:0]  o_slot;
  logic [BoardW-1:0] o_bits;

  // no bytes while the boards of a finished string are going out
  assign in_tready = !emit_busy;
  assign in_fire   = in_tvalid && in_tready;

  fpp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .symbol  (in_tdata),
    .last    (in_tlast),
    .rd_data (mem_rd_data),
    .rd      (p_rd),
    .wr      (p_wr),
    .snap    (p_snap)
  );

  // the parser reads only on an accepted byte, the sequencer only while busy
  assign m_rd.en   = p_rd.en || e_rd.en;
  assign m_rd.addr = emit_busy ? e_rd.addr : p_rd.addr;

  fpp_board_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (m_rd),
    .wr      (p_wr),
    .clr     (mem_clr),
    .rd_data (mem_rd_data)
  );

  fpp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire && in_tlast),
    .snap      (p_snap),
    .rd_data   (mem_rd_data),
    .out_ready (out_tready),
    .rd        (e_rd),
    .clr       (mem_clr),
    .busy      (emit_busy),
    .out_valid (out_tvalid),
    .out_slot  (o_slot),
    .out_bits  (o_bits),
    .out_snap  (o_snap),
    .out_last  (out_tlast)
  );

  assign out_tuser = o_slot;
  assign out_tdata = {4'd0, o_snap.full, o_snap.half, o_snap.ep_square,
                      o_snap.ep_valid, o_snap.castle, o_snap.side_white, o_bits};

  a_no_rd_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(p_rd.en && e_rd.en))
    else $error("parser and sequencer read the store together");

  a_no_wr_on_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(p_wr.en && mem_clr))
    else $error("board write collides with the store clear");

endmodule

// File: dv/tb_fen_position_parser.sv
// ----------------------------------------------------------------------------
// tb_fen_position_parser: self-checking bench for the position string parser
// feeds position strings a byte at a time, predicts the fifteen boards each
// string yields and checks every result transaction field by field, with
// bursty input, a stalling receiver and one long output hold-off
// ----------------------------------------------------------------------------
module tb_fen_position_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import fpp_pkg::*;

  // placement cursor and field numbering of a position string
  localparam logic [7:0] START_SQ   = 8'd56;
  localparam logic [7:0] RANK_BACK  = 8'd16;
  localparam int         FLD_PLACE  = 0;
  localparam int         FLD_SIDE   = 1;
  localparam int         FLD_CASTLE = 2;
  localparam int         FLD_EP     = 3;
  localparam int         FLD_HALF   = 4;
  localparam int         FLD_FULL   = 5;
  localparam int         FLD_LIMIT  = 7;

  // castling right bits
  localparam int CASTLE_WK = 0;
  localparam int CASTLE_WQ = 1;
  localparam int CASTLE_BK = 2;
  localparam int CASTLE_BQ = 3;

  // run length and limits
  localparam int RANDOM_ITEMS = 160;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // one expected board transaction
  typedef struct {
    logic [SlotW-1:0]  slot;
    logic [BoardW-1:0] bits;
    snap_t             scalars;
    logic              last;
  } board_result_t;

  // clock, reset and dut ports, the bench-driven ones known from time zero
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;
  logic [OutTuserW-1:0] out_tuser;
  logic                 out_tlast;

  // predicted parser state
  logic [BoardW-1:0] occupancy [NumBoards];
  logic [7:0]        cursor;
  logic [2:0]        field_idx;
  logic              turn_white;
  logic [3:0]        rights;
  logic              ep_ok;
  logic [5:0]        ep_sq;
  logic              file_waiting;
  logic [2:0]        file_held;
  logic [15:0]       halfmoves;
  logic [15:0]       fullmoves;

  // expected boards in arrival order
  board_result_t board_queue [$];

  // bytes of the string being built
  logic [7:0] text_buf [$];

  // sender and receiver knobs
  int        burst_left     = 0;
  bit        gaps_on        = 1'b0;
  rx_mode_t  ready_mode     = RX_ALWAYS;
  logic [15:0] stall_pattern = 16'hFFFF;
  bit        hold_req       = 1'b0;
  int        hold_left      = 0;

  int items_sent     = 0;
  int mismatch_count = 0;

  fen_position_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // clears what a finished string leaves behind; turn and en passant persist
  function automatic void clear_run();
    foreach (occupancy[i]) occupancy[i] = '0;
    cursor       = START_SQ;
    field_idx    = FLD_PLACE;
    rights       = '0;
    file_waiting = 1'b0;
    file_held    = '0;
    halfmoves    = '0;
    fullmoves    = '0;
  endfunction

  // decimal accumulate, saturating at the counter maximum
  function automatic logic [15:0] count_digit(input logic [15:0] acc, input logic [7:0] dig);
    int sum;
    sum = int'(acc) * 10 + int'(dig);
    return (sum > 65535) ? 16'hFFFF : sum[15:0];
  endfunction

  // advances the predicted state by one accepted byte, queues boards on the last
  function automatic void parse_symbol(input logic [7:0] sym, input logic ends);
    logic              is_digit;
    logic [7:0]        dig;
    logic              consumed;
    int                slot_idx;
    int                ep_idx;
    logic [BoardW-1:0] white_set;
    logic [BoardW-1:0] black_set;
    board_result_t     res;
    is_digit = (sym >= "0") && (sym <= "9");
    dig      = sym - "0";
    consumed = 1'b0;
    case (sym)
      "P": slot_idx = SLOT_W_PAWN;
      "R": slot_idx = SLOT_W_ROOK;
      "N": slot_idx = SLOT_W_KNIGHT;
      "B": slot_idx = SLOT_W_BISHOP;
      "Q": slot_idx = SLOT_W_QUEEN;
      "K": slot_idx = SLOT_W_KING;
      "p": slot_idx = SLOT_B_PAWN;
      "r": slot_idx = SLOT_B_ROOK;
      "n": slot_idx = SLOT_B_KNIGHT;
      "b": slot_idx = SLOT_B_BISHOP;
      "q": slot_idx = SLOT_B_QUEEN;
      "k": slot_idx = SLOT_B_KING;
      default: slot_idx = -1;
    endcase

    // a held en passant file eats the next digit, square kept only on the board
    if (file_waiting) begin
      file_waiting = 1'b0;
      if (is_digit) begin
        consumed = 1'b1;
        ep_idx = int'(file_held) + (int'(dig) - 1) * 8;
        if (ep_idx >= 0 && ep_idx <= 63) begin
          ep_ok = 1'b1;
          ep_sq = ep_idx[5:0];
        end
      end
    end

    if (!consumed) begin
      if (field_idx == FLD_PLACE) begin
        if (is_digit) begin
          cursor = cursor + dig;
        end else if (sym == "/") begin
          cursor = cursor - RANK_BACK;
        end else begin
          // off-board squares drop the bit but still advance the cursor
          if (slot_idx >= 0 && cursor < 8'd64) occupancy[slot_idx][cursor[5:0]] = 1'b1;
          cursor = cursor + 8'd1;
        end
      end
      if (sym == " " && field_idx < FLD_LIMIT) field_idx = field_idx + 3'd1;

      case (int'(field_idx))
        FLD_SIDE: begin
          if (sym == "w") turn_white = 1'b1;
          if (sym == "b") turn_white = 1'b0;
        end
        FLD_CASTLE: begin
          if (sym == "K") rights[CASTLE_WK] = 1'b1;
          if (sym == "Q") rights[CASTLE_WQ] = 1'b1;
          if (sym == "k") rights[CASTLE_BK] = 1'b1;
          if (sym == "q") rights[CASTLE_BQ] = 1'b1;
          if (sym == "-") rights = '0;
        end
        FLD_EP: begin
          if (sym == "-") begin
            ep_ok = 1'b0;
          end else if (sym >= "a" && sym <= "h") begin
            file_waiting = 1'b1;
            file_held    = 3'(sym - "a");
          end
        end
        FLD_HALF: if (is_digit) halfmoves = count_digit(halfmoves, dig);
        FLD_FULL: if (is_digit) fullmoves = count_digit(fullmoves, dig);
        default: ;
      endcase
    end

    if (ends) begin
      white_set = '0;
      black_set = '0;
      for (int k = 0; k < 6; k++) begin
        white_set |= occupancy[k];
        black_set |= occupancy[k + 6];
      end
      for (int k = 0; k <= int'(SLOT_ALL); k++) begin
        res.slot = 4'(k);
        if (k < NumBoards) res.bits = occupancy[k];
        else if (k == SLOT_WHITE) res.bits = white_set;
        else if (k == SLOT_BLACK) res.bits = black_set;
        else res.bits = white_set | black_set;
        res.scalars.side_white = turn_white;
        res.scalars.castle     = rights;
        res.scalars.ep_valid   = ep_ok;
        res.scalars.ep_square  = ep_ok ? ep_sq : '0;
        res.scalars.half       = halfmoves;
        res.scalars.full       = fullmoves;
        res.last               = (k == SLOT_ALL);
        board_queue.push_back(res);
      end
      clear_run();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offers one byte, holding it until the parser takes it
  task automatic send_symbol(input logic [7:0] sym, input logic ends);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= ends;
    do @(posedge clk); while (!in_tready);
    parse_symbol(sym, ends);
    items_sent++;
  endtask

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  // sends the built string, tlast on its final byte
  task automatic send_text_buf();
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) send_symbol(text_buf[i], i == n - 1);
    text_buf.delete();
  endtask

  // random position string, mostly well formed, sometimes broken or pure noise
  function automatic void build_position();
    string letters;
    int    ranks;
    int    filled;
    int    n;
    int    cut;
    int    pick;
    letters = "PRNBQKprnbqk";
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end

    // placement, occasionally too many ranks or stray bytes
    ranks = ($urandom_range(0, 2) == 0) ? 8 : $urandom_range(1, 4);
    if ($urandom_range(0, 15) == 0) ranks = 9;
    for (int r = 0; r < ranks; r++) begin
      if (r != 0) text_buf.push_back("/");
      filled = 0;
      while (filled < 8) begin
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 8 - filled);
          if ($urandom_range(0, 19) == 0) n = 9;
          text_buf.push_back(8'("0" + n));
          filled += n;
        end else begin
          text_buf.push_back(letters[$urandom_range(0, 11)]);
          filled++;
        end
        if ($urandom_range(0, 39) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
      end
    end

    // trailing fields, sometimes cut short or with junk after the move count
    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : FLD_FULL;
    for (int f = FLD_SIDE; f <= cut; f++) begin
      text_buf.push_back(" ");
      case (f)
        FLD_SIDE: begin
          pick = $urandom_range(0, 9);
          if (pick < 5) append_text("w");
          else if (pick < 9) append_text("b");
          else text_buf.push_back(8'($urandom_range(0, 255)));
        end
        FLD_CASTLE: begin
          if ($urandom_range(0, 3) == 0) begin
            append_text("-");
          end else begin
            if ($urandom_range(0, 1)) append_text("K");
            if ($urandom_range(0, 1)) append_text("Q");
            if ($urandom_range(0, 5) == 0) append_text("-");
            if ($urandom_range(0, 1)) append_text("k");
            if ($urandom_range(0, 1)) append_text("q");
          end
        end
        FLD_EP: begin
          pick = $urandom_range(0, 19);
          if (pick < 8) begin
            append_text("-");
          end else begin
            text_buf.push_back(8'("a" + $urandom_range(0, 7)));
            if (pick < 16) append_text($urandom_range(0, 1) ? "3" : "6");
            else if (pick < 19) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
            else append_text("-");
          end
        end
        FLD_HALF, FLD_FULL: begin
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
          repeat (n) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) text_buf.push_back(($urandom_range(0, 2) == 0) ? 8'(" ")
                                                                     : 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: long hold-off on request, otherwise its current stall mode
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 99) < 70);
        default:   out_tready <= stall_pattern[0];
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v, input logic [SlotW-1:0] slot);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("board %0d %s mismatch: expected %0h, got %0h", slot, name, exp_v, act_v);
    end
  endfunction

  // compares each result transaction against the oldest expected board
  always @(posedge clk) begin : result_check
    board_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (board_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected board transaction, slot %0d", out_tuser);
      end else begin
        exp_r = board_queue.pop_front();
        check_field("board_slot", 64'(exp_r.slot), 64'(out_tuser), exp_r.slot);
        check_field("board_bits", exp_r.bits, out_tdata[63:0], exp_r.slot);
        check_field("white_to_move", 64'(exp_r.scalars.side_white), 64'(out_tdata[64]),
                    exp_r.slot);
        check_field("castle_white_king", 64'(exp_r.scalars.castle[CASTLE_WK]),
                    64'(out_tdata[65]), exp_r.slot);
        check_field("castle_white_queen", 64'(exp_r.scalars.castle[CASTLE_WQ]),
                    64'(out_tdata[66]), exp_r.slot);
        check_field("castle_black_king", 64'(exp_r.scalars.castle[CASTLE_BK]),
                    64'(out_tdata[67]), exp_r.slot);
        check_field("castle_black_queen", 64'(exp_r.scalars.castle[CASTLE_BQ]),
                    64'(out_tdata[68]), exp_r.slot);
        check_field("passant_valid", 64'(exp_r.scalars.ep_valid), 64'(out_tdata[69]),
                    exp_r.slot);
        check_field("passant_square", 64'(exp_r.scalars.ep_square), 64'(out_tdata[75:70]),
                    exp_r.slot);
        check_field("halfmove_clock", 64'(exp_r.scalars.half), 64'(out_tdata[91:76]),
                    exp_r.slot);
        check_field("fullmove_number", 64'(exp_r.scalars.full), 64'(out_tdata[107:92]),
                    exp_r.slot);
        check_field("tdata padding", '0, 64'(out_tdata[111:108]), exp_r.slot);
        check_field("run_last", 64'(exp_r.last), 64'(out_tlast), exp_r.slot);
      end
    end
  end

  // watchdog: too many cycles without any transaction on either side
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all twelve piece letters plus the lowest and highest byte in placement
  task automatic test_piece_letters();
    ready_mode = RX_ALWAYS;
    gaps_on    = 1'b0;
    append_text("PRNBQK");
    text_buf.push_back(8'h00);
    append_text("prnbqk");
    text_buf.push_back(8'hFF);
    append_text(" w");
    send_text_buf();
  endtask

  // last square of the board, cursor running off the board and wrapping back
  task automatic test_square_wrap();
    ready_mode = RX_RANDOM;
    gaps_on    = 1'b1;
    append_text("7Rr////9P b");
    send_text_buf();
  endtask

  // side, castling cleared mid-field, rejected and accepted en passant,
  // saturating counts and fields past the move count
  task automatic test_scalar_fields();
    ready_mode    = RX_PATTERN;
    stall_pattern = 16'b1011_0110_1110_0101;
    append_text("k b Kq-Q -a0h9e3 70000 99999 7 7x");
    send_text_buf();
  endtask

  // en passant file left pending at the end must not eat the next string's digit
  task automatic test_pending_file();
    ready_mode = RX_RANDOM;
    append_text("8 w - c");
    send_text_buf();
    append_text("3p w");
    send_text_buf();
  endtask

  // long output hold-off while strings keep coming, so the input stalls
  task automatic test_output_hold();
    ready_mode = RX_ALWAYS;
    gaps_on    = 1'b0;
    hold_req   = 1'b1;
    repeat (2) begin
      build_position();
      send_text_buf();
    end
  endtask

  // random strings under varying input gaps and receiver stall modes
  task automatic test_random_positions();
    int first;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      gaps_on       = ($urandom_range(0, 3) != 0);
      ready_mode    = rx_mode_t'($urandom_range(0, 2));
      stall_pattern = 16'($urandom) | 16'h0001;
      build_position();
      send_text_buf();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_run();
    turn_white = 1'b1;
    ep_ok      = 1'b0;
    ep_sq      = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_piece_letters();
    test_square_wrap();
    test_scalar_fields();
    test_pending_file();
    test_output_hold();
    test_random_positions();

    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain, then keep watching for any stray transaction
    while (board_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
